FILE: sv/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit.
// ---------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 4;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = ((VALUE_W + INDEX_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_DELETE_AT  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // read port address source
    typedef enum logic [2:0] {
        RD_NONE  = 3'd0,
        RD_BACK  = 3'd1,
        RD_FRONT = 3'd2,
        RD_INDEX = 3'd3,
        RD_NEXT  = 3'd4
    } t_rd_sel;

    // result data source
    typedef enum logic [1:0] {
        OUT_ZERO = 2'd0,
        OUT_RD   = 2'd1,
        OUT_HELD = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     push_back;
        logic     push_front;
        logic     pop_back;
        logic     pop_front;
        t_rd_sel  rd_sel;
        logic     shift_wr;
        logic     dec_fill;
        logic     hold_data;
        logic     out_load;
        t_out_sel out_sel;
        t_status  out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_bad;
        logic cur_at_fill;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: sv/deq_dp.sv
// ---------------------------------------------------------------------------
// deq_dp
// Datapath: ring storage, head and fill pointers, shift cursor, result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_dp #(
    parameter int  CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int  DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire deq_pkg::t_dp_cmd             i_cmd,
    input  wire logic [deq_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [deq_pkg::INDEX_W-1:0]  i_index,
    output deq_pkg::t_dp_stat                 o_stat,
    output logic [deq_pkg::VALUE_W-1:0]       o_data,
    output logic [CNT_W-1:0]                  o_count,
    output deq_pkg::t_status                  o_status
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > deq_pkg::INDEX_W) ? CNT_W : deq_pkg::INDEX_W;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [ADDR_W-1:0]     r_head;
    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      r_cur;
    logic [ADDR_W-1:0]     r_rd_pos;
    logic [ADDR_W-1:0]     r_prev;
    logic [DATA_WIDTH-1:0] r_rd_q;
    logic [DATA_WIDTH-1:0] r_held;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic [CNT_W-1:0]      r_out_count;
    deq_pkg::t_status      r_out_status;

    logic [ADDR_W-1:0]     n_head;
    logic [CNT_W-1:0]      n_fill;

    logic [DATA_WIDTH-1:0] w_val;
    logic [CMP_W-1:0]      w_idx_x;
    logic [ADDR_W-1:0]     w_raddr;
    logic                  w_re;
    logic [ADDR_W-1:0]     w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_we;
    logic [ADDR_W-1:0]     w_head_dec;

    // ring position of the entry at offset off from the front
    function automatic logic [ADDR_W-1:0] f_ring(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (s >= (CNT_W + 1)'(CAPACITY)) begin
            s = s - (CNT_W + 1)'(CAPACITY);
        end
        return s[ADDR_W-1:0];
    endfunction

    generate
        if (DATA_WIDTH > deq_pkg::VALUE_W) begin : g_wide
            assign w_val  = {{(DATA_WIDTH - deq_pkg::VALUE_W){1'b0}}, i_value};
            assign o_data = r_out_data[deq_pkg::VALUE_W-1:0];
        end else if (DATA_WIDTH == deq_pkg::VALUE_W) begin : g_equal
            assign w_val  = i_value;
            assign o_data = r_out_data;
        end else begin : g_narrow
            assign w_val  = i_value[DATA_WIDTH-1:0];
            assign o_data = {{(deq_pkg::VALUE_W - DATA_WIDTH){1'b0}}, r_out_data};
        end
    endgenerate

    assign w_idx_x    = CMP_W'(i_index);
    assign w_head_dec = (r_head == '0) ? ADDR_W'(CAPACITY - 1) : r_head - ADDR_W'(1);

    assign o_stat.full        = (r_fill == CNT_W'(CAPACITY));
    assign o_stat.empty       = (r_fill == '0);
    assign o_stat.idx_bad     = (w_idx_x >= CMP_W'(r_fill));
    assign o_stat.cur_at_fill = (r_cur == r_fill);

    assign o_count  = r_out_count;
    assign o_status = r_out_status;

    always_comb begin
        case (i_cmd.rd_sel)
            deq_pkg::RD_BACK:  w_raddr = f_ring(r_head, r_fill - CNT_W'(1));
            deq_pkg::RD_FRONT: w_raddr = r_head;
            deq_pkg::RD_INDEX: w_raddr = f_ring(r_head, w_idx_x[CNT_W-1:0]);
            deq_pkg::RD_NEXT:  w_raddr = f_ring(r_head, r_cur);
            default:           w_raddr = r_head;
        endcase
        w_re = (i_cmd.rd_sel != deq_pkg::RD_NONE);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_prev;
        w_wdata = r_rd_q;
        if (i_cmd.push_back) begin
            w_we    = 1'b1;
            w_waddr = f_ring(r_head, r_fill);
            w_wdata = w_val;
        end else if (i_cmd.push_front) begin
            w_we    = 1'b1;
            w_waddr = w_head_dec;
            w_wdata = w_val;
        end else if (i_cmd.shift_wr) begin
            w_we    = 1'b1;
        end
    end

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.push_back || i_cmd.push_front) begin
            n_fill = r_fill + CNT_W'(1);
        end
        if (i_cmd.pop_back || i_cmd.pop_front || i_cmd.dec_fill) begin
            n_fill = r_fill - CNT_W'(1);
        end
        if (i_cmd.push_front) begin
            n_head = w_head_dec;
        end
        if (i_cmd.pop_front) begin
            n_head = f_ring(r_head, CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_q   <= mem[w_raddr];
            r_rd_pos <= w_raddr;
            r_prev   <= r_rd_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur <= w_idx_x[CNT_W-1:0] + CNT_W'(1);
        end else if (i_cmd.rd_sel == deq_pkg::RD_NEXT) begin
            r_cur <= r_cur + CNT_W'(1);
        end
        if (i_cmd.hold_data) begin
            r_held <= r_rd_q;
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                deq_pkg::OUT_RD:   r_out_data <= r_rd_q;
                deq_pkg::OUT_HELD: r_out_data <= r_held;
                default:           r_out_data <= '0;
            endcase
            r_out_count  <= r_fill;
            r_out_status <= i_cmd.out_status;
        end
    end

endmodule

`default_nettype wire

FILE: sv/deq_ctrl.sv
// ---------------------------------------------------------------------------
// deq_ctrl
// Controller: accepts one word at a time, sequences the delete shift,
// and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire deq_pkg::t_op      i_op,
    input  wire logic              i_m_tready,
    input  wire deq_pkg::t_dp_stat i_stat,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    output deq_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL_HEAD,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state           r_state;
    t_state           n_state;
    deq_pkg::t_op     r_op;
    deq_pkg::t_status r_status;
    logic             r_out_valid;
    deq_pkg::t_status n_status;
    logic             w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign w_accept   = (r_state == S_IDLE) && i_s_tvalid;

    always_comb begin
        case (i_op)
            deq_pkg::OP_PUSH_BACK,
            deq_pkg::OP_PUSH_FRONT:
                n_status = i_stat.full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
            deq_pkg::OP_POP_BACK,
            deq_pkg::OP_POP_FRONT:
                n_status = i_stat.empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_OK;
            deq_pkg::OP_READ_AT,
            deq_pkg::OP_DELETE_AT:
                n_status = i_stat.idx_bad ? deq_pkg::ST_BAD_INDEX : deq_pkg::ST_OK;
            default:
                n_status = deq_pkg::ST_OK;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = deq_pkg::RD_NONE;
        o_cmd.out_sel    = deq_pkg::OUT_ZERO;
        o_cmd.out_status = r_status;
        n_state          = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RESP;
                    if (n_status == deq_pkg::ST_OK) begin
                        case (i_op)
                            deq_pkg::OP_PUSH_BACK:  o_cmd.push_back = 1'b1;
                            deq_pkg::OP_PUSH_FRONT: o_cmd.push_front = 1'b1;
                            deq_pkg::OP_POP_BACK: begin
                                o_cmd.pop_back = 1'b1;
                                o_cmd.rd_sel   = deq_pkg::RD_BACK;
                            end
                            deq_pkg::OP_POP_FRONT: begin
                                o_cmd.pop_front = 1'b1;
                                o_cmd.rd_sel    = deq_pkg::RD_FRONT;
                            end
                            deq_pkg::OP_READ_AT: o_cmd.rd_sel = deq_pkg::RD_INDEX;
                            deq_pkg::OP_DELETE_AT: begin
                                o_cmd.rd_sel = deq_pkg::RD_INDEX;
                                n_state      = S_DEL_HEAD;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_DEL_HEAD: begin
                // keep the removed word, then walk the later entries forward
                o_cmd.hold_data = 1'b1;
                if (i_stat.cur_at_fill) begin
                    o_cmd.dec_fill = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.rd_sel = deq_pkg::RD_NEXT;
                    n_state      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (i_stat.cur_at_fill) begin
                    o_cmd.dec_fill = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.rd_sel = deq_pkg::RD_NEXT;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                    if (r_status == deq_pkg::ST_OK) begin
                        case (r_op)
                            deq_pkg::OP_POP_BACK,
                            deq_pkg::OP_POP_FRONT,
                            deq_pkg::OP_READ_AT:   o_cmd.out_sel = deq_pkg::OUT_RD;
                            deq_pkg::OP_DELETE_AT: o_cmd.out_sel = deq_pkg::OUT_HELD;
                            default:               o_cmd.out_sel = deq_pkg::OUT_ZERO;
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= deq_pkg::OP_PUSH_BACK;
            r_status    <= deq_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_op     <= i_op;
                r_status <= n_status;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/double_ended_queue_unit.sv
// Push, pop and read go from accept to the response state, which loads the
// result register; delete first walks each later entry forward, one per step.
// A new word is taken only in the idle state, after the result register is
// loaded, which waits on a stalled output; delete holds off input for its walk.
// Reset (i_rst_n low, synchronous): queue empty, head at slot 0, no result
// pending. Storage contents are not cleared; only written entries are read.
// ---------------------------------------------------------------------------
// double_ended_queue_unit
// Fixed-depth double-ended queue of handles in a ring, with push and pop at
// both ends, indexed read and indexed delete that closes the gap.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit #(
    parameter int  CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int  DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W  = ((deq_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input word stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: value[31:0], index[35:32], zero pad above
    input  wire logic [deq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation[2:0]
    input  wire logic [deq_pkg::OP_W-1:0]       s_axis_tuser,
    // result word stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: data[31:0], count[CNT_W+31:32], zero pad above
    output logic [M_TDATA_W-1:0]                m_axis_tdata,
    // tuser: status[1:0]
    output logic [deq_pkg::STATUS_W-1:0]        m_axis_tuser
);

    deq_pkg::t_dp_cmd                w_cmd;
    deq_pkg::t_dp_stat               w_stat;
    logic [deq_pkg::VALUE_W-1:0]     w_data;
    logic [CNT_W-1:0]                w_count;
    deq_pkg::t_status                w_status;

    // Controller: takes one word, issues storage reads/writes, walks the
    // delete shift and loads the result register when the output is free.
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (deq_pkg::t_op'(s_axis_tuser)),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    // Datapath: ring storage with one write and one registered read port,
    // head/fill pointers, and the result payload register.
    deq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (s_axis_tdata[deq_pkg::VALUE_W-1:0]),
        .i_index  (s_axis_tdata[deq_pkg::VALUE_W+deq_pkg::INDEX_W-1:deq_pkg::VALUE_W]),
        .o_stat   (w_stat),
        .o_data   (w_data),
        .o_count  (w_count),
        .o_status (w_status)
    );

    // Pack the result word: data low, count above, zero pad on top.
    assign m_axis_tdata = M_TDATA_W'({w_count, w_data});
    assign m_axis_tuser = w_status;

`ifndef SYNTHESIS
    // The count never runs past the ring depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count <= CNT_W'(CAPACITY)))
        else $error("result count exceeds capacity");

    // A refused or failed operation hands back no data.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status != deq_pkg::ST_OK)) |-> (w_data == '0))
        else $error("error result carries nonzero data");

    // Full is only reported with the ring full, empty only with it empty.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status == deq_pkg::ST_FULL)) |->
            (w_count == CNT_W'(CAPACITY)))
        else $error("full status with ring not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status == deq_pkg::ST_EMPTY)) |-> (w_count == '0))
        else $error("empty status with entries held");

    // One word in flight: an accept always drops ready for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is in progress");
`endif

endmodule

`default_nettype wire
